[rtl/trapezoid_motion_profile_assert.svh]
// Assertion macros for the motion profile block.
`ifndef TRAPEZOID_MOTION_PROFILE_ASSERT_SVH
`define TRAPEZOID_MOTION_PROFILE_ASSERT_SVH
`ifndef SYNTHESIS
`define TMP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("motion profile check failed");
`define TMP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("motion profile check failed");
`else
`define TMP_ASSERT_NOW(lbl, ante, cons)
`define TMP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[rtl/tmp_pkg.sv]
package tmp_pkg;

  localparam int TMP_FRAC_BITS = 16;

  typedef enum logic [1:0] {
    PH_ACCEL  = 2'd0,
    PH_CRUISE = 2'd1,
    PH_DECEL  = 2'd2,
    PH_ARRIVE = 2'd3
  } tmp_phase_t;

  typedef enum logic [1:0] {
    REG_START = 2'd0,
    REG_GOAL  = 2'd1,
    REG_PEAK  = 2'd2,
    REG_ACCEL = 2'd3
  } tmp_reg_t;

  typedef enum logic [3:0] {
    SQ_IDLE,
    SQ_LOAD,
    SQ_MDA,
    SQ_MVV,
    SQ_SQRT,
    SQ_DTP,
    SQ_MAT,
    SQ_MRD,
    SQ_DTC,
    SQ_DONE
  } tmp_seq_t;

  // move values derived from the config registers
  typedef struct packed {
    logic [63:0]        tp;
    logic [63:0]        tce;
    logic [63:0]        tend;
    logic [63:0]        rd;
    logic [30:0]        accel;
    logic [30:0]        peak;
    logic [31:0]        span;
    logic signed [31:0] start;
    logic signed [31:0] goal;
    logic               neg;
  } tmp_prof_t;

  // floor(p / 2^k), saturated to 64 bits
  function automatic logic [63:0] tmp_sat_shr(input logic [127:0] p, input int unsigned k);
    logic [127:0] hi;
    logic [127:0] lo;
    hi = p >> (64 + k);
    lo = p >> k;
    tmp_sat_shr = (hi != '0) ? '1 : lo[63:0];
  endfunction

endpackage

[rtl/tmp_cfg.sv]
module tmp_cfg #(
  parameter int FRAC_BITS = tmp_pkg::TMP_FRAC_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_addr,
  input  logic [31:0]         cfg_data,
  output logic                busy,
  output tmp_pkg::tmp_prof_t  prof
);
  import tmp_pkg::*;

  localparam int RSH = 2 * FRAC_BITS + 1;
  localparam logic [5:0] LAST_LONG = 6'd63;
  localparam logic [5:0] LAST_SQRT = 6'd31;

  tmp_seq_t state, state_next;

  logic signed [31:0] start_angle, goal_angle;
  logic [30:0]        peak_velocity, accel_rate;

  logic [5:0]   cnt;
  logic [127:0] mc_acc, mc_a;
  logic [63:0]  mc_b;
  logic [63:0]  dv_q;
  logic [30:0]  dv_r, dv_d;
  logic [63:0]  sq_n, sq_res, sq_bit;
  logic [63:0]  da, tp, tc, rd, tce, tend;
  logic         trap;

  logic         wr;
  logic [32:0]  diff;
  logic         neg;
  logic [31:0]  dq;
  logic [30:0]  a_eff, v_eff;
  logic         long_done, sqrt_done;

  logic [127:0] mul_res;
  logic [31:0]  dv_t;
  logic         dv_ge;
  logic [31:0]  dv_rn;
  logic [63:0]  dv_qn;
  logic [63:0]  sq_t;
  logic         sq_ge;
  logic [63:0]  sq_res_n;
  logic [63:0]  rd_now, two_rd;
  logic         trap_now, cruise_now;

  assign wr = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_angle   <= '0;
      goal_angle    <= '0;
      peak_velocity <= 31'(65'd1 << FRAC_BITS);
      accel_rate    <= 31'(65'd1 << FRAC_BITS);
    end else if (wr) begin
      case (tmp_reg_t'(cfg_addr))
        REG_START: start_angle   <= cfg_data;
        REG_GOAL:  goal_angle    <= cfg_data;
        REG_PEAK:  peak_velocity <= cfg_data[30:0];
        REG_ACCEL: accel_rate    <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // distance and direction
  assign diff  = {goal_angle[31], goal_angle} - {start_angle[31], start_angle};
  assign neg   = diff[32] || (diff == '0);
  assign dq    = neg ? 32'(-diff) : diff[31:0];
  assign a_eff = (accel_rate == '0) ? 31'd1 : accel_rate;
  assign v_eff = (peak_velocity == '0) ? 31'd1 : peak_velocity;

  assign long_done = (cnt == LAST_LONG);
  assign sqrt_done = (cnt == LAST_SQRT);

  // serial multiply, restoring divide, digit-by-digit square root
  assign mul_res  = mc_b[0] ? mc_acc + mc_a : mc_acc;
  assign dv_t     = {dv_r, dv_q[63]};
  assign dv_ge    = dv_t >= {1'b0, dv_d};
  assign dv_rn    = dv_ge ? dv_t - {1'b0, dv_d} : dv_t;
  assign dv_qn    = {dv_q[62:0], dv_ge};
  assign sq_t     = sq_res + sq_bit;
  assign sq_ge    = sq_n >= sq_t;
  assign sq_res_n = sq_ge ? (sq_res >> 1) + sq_bit : sq_res >> 1;

  assign trap_now   = da > mul_res[63:0];
  assign rd_now     = tmp_sat_shr(mul_res, RSH);
  assign two_rd     = {rd_now[62:0], 1'b0};
  assign cruise_now = trap && (two_rd <= {32'd0, dq});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SQ_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      SQ_IDLE: if (wr) state_next = SQ_LOAD;
      SQ_LOAD: state_next = SQ_MDA;
      SQ_MDA:  if (long_done) state_next = SQ_MVV;
      SQ_MVV:  if (long_done) state_next = trap_now ? SQ_DTP : SQ_SQRT;
      SQ_SQRT: if (sqrt_done) state_next = SQ_DTP;
      SQ_DTP:  if (long_done) state_next = SQ_MAT;
      SQ_MAT:  if (long_done) state_next = SQ_MRD;
      SQ_MRD:  if (long_done) state_next = cruise_now ? SQ_DTC : SQ_DONE;
      SQ_DTC:  if (long_done) state_next = SQ_DONE;
      SQ_DONE: state_next = SQ_IDLE;
      default: state_next = SQ_LOAD;
    endcase
  end

  always_comb begin
    busy      = (state != SQ_IDLE);
    cfg_ready = (state == SQ_IDLE);
  end

  always_ff @(posedge clk) begin
    cnt    <= cnt + 6'd1;
    mc_acc <= mul_res;
    mc_a   <= mc_a << 1;
    mc_b   <= mc_b >> 1;
    dv_q   <= dv_qn;
    dv_r   <= dv_rn[30:0];
    sq_res <= sq_res_n;
    sq_bit <= sq_bit >> 2;
    if (sq_ge) begin
      sq_n <= sq_n - sq_t;
    end
    case (state)
      SQ_LOAD: begin
        cnt    <= '0;
        mc_acc <= '0;
        mc_a   <= {96'd0, dq};
        mc_b   <= {33'd0, a_eff};
      end
      SQ_MDA: begin
        if (long_done) begin
          da     <= mul_res[63:0];
          cnt    <= '0;
          mc_acc <= '0;
          mc_a   <= {97'd0, v_eff};
          mc_b   <= {33'd0, v_eff};
        end
      end
      SQ_MVV: begin
        if (long_done) begin
          trap <= trap_now;
          cnt  <= '0;
          if (trap_now) begin
            dv_q <= 64'({33'd0, v_eff} << FRAC_BITS);
            dv_r <= '0;
            dv_d <= a_eff;
          end else begin
            sq_n   <= da;
            sq_res <= '0;
            sq_bit <= 64'd1 << 62;
          end
        end
      end
      SQ_SQRT: begin
        if (sqrt_done) begin
          cnt  <= '0;
          dv_q <= sq_res_n << FRAC_BITS;
          dv_r <= '0;
          dv_d <= a_eff;
        end
      end
      SQ_DTP: begin
        if (long_done) begin
          tp     <= dv_qn;
          cnt    <= '0;
          mc_acc <= '0;
          mc_a   <= {64'd0, dv_qn};
          mc_b   <= {33'd0, a_eff};
        end
      end
      SQ_MAT: begin
        if (long_done) begin
          cnt    <= '0;
          mc_acc <= '0;
          mc_a   <= {64'd0, mul_res[63:0]};
          mc_b   <= tp;
        end
      end
      SQ_MRD: begin
        if (long_done) begin
          rd   <= rd_now;
          tc   <= '0;
          cnt  <= '0;
          dv_q <= ({32'd0, dq} - two_rd) << FRAC_BITS;
          dv_r <= '0;
          dv_d <= v_eff;
        end
      end
      SQ_DTC: begin
        if (long_done) begin
          tc <= dv_qn;
        end
      end
      SQ_DONE: begin
        tce  <= tp + tc;
        tend <= tp + tc + tp;
      end
      default: ;
    endcase
  end

  always_comb begin
    prof.tp    = tp;
    prof.tce   = tce;
    prof.tend  = tend;
    prof.rd    = rd;
    prof.accel = a_eff;
    prof.peak  = v_eff;
    prof.span  = dq;
    prof.start = start_angle;
    prof.goal  = goal_angle;
    prof.neg   = neg;
  end

endmodule

[rtl/tmp_eval.sv]
module tmp_eval #(
  parameter int FRAC_BITS = tmp_pkg::TMP_FRAC_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  tmp_pkg::tmp_prof_t  prof,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [31:0]         in_time,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  out_angle,
  output tmp_pkg::tmp_phase_t out_phase
);
  import tmp_pkg::*;

  localparam int RSH = 2 * FRAC_BITS + 1;

  logic v1, v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5, en6;

  // stage payloads
  tmp_phase_t  ph1, ph2, ph3, ph4, ph5;
  logic [31:0] x1, x2;
  logic [63:0] m2, m3;
  logic [63:0] pl3, ph3p;
  logic [63:0] val4;
  logic [31:0] s5;

  logic [63:0]  t64;
  tmp_phase_t   ph_in;
  logic [31:0]  x_in;
  logic [30:0]  mult_in;
  logic [62:0]  m_in;
  logic [127:0] full;
  logic [63:0]  ramp;
  logic [63:0]  s_raw;
  logic [33:0]  st34, s34, sum;

  assign en6 = !out_valid || out_ready;
  assign en5 = !v5 || en6;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
      if (en6) out_valid <= v5;
    end
  end

  // segment select
  assign t64 = {32'd0, in_time};
  always_comb begin
    if (t64 <= prof.tp) begin
      ph_in = PH_ACCEL;
      x_in  = in_time;
    end else if (t64 <= prof.tce) begin
      ph_in = PH_CRUISE;
      x_in  = in_time - prof.tp[31:0];
    end else if (t64 <= prof.tend) begin
      ph_in = PH_DECEL;
      x_in  = 32'(prof.tend - t64);
    end else begin
      ph_in = PH_ARRIVE;
      x_in  = '0;
    end
  end

  assign mult_in = (ph1 == PH_CRUISE) ? prof.peak : prof.accel;
  assign m_in    = 63'(mult_in) * 63'(x1);

  // ramp product a*x*x, then distance along the move
  assign full = {64'd0, pl3} + ({64'd0, ph3p} << 32);
  assign ramp = tmp_sat_shr(full, RSH);

  always_comb begin
    case (ph4)
      PH_ACCEL, PH_CRUISE: s_raw = val4;
      PH_DECEL: begin
        s_raw = (val4 <= {32'd0, prof.span}) ? {32'd0, prof.span} - val4 : '0;
      end
      default:             s_raw = {32'd0, prof.span};
    endcase
    if (s_raw > {32'd0, prof.span}) begin
      s_raw = {32'd0, prof.span};
    end
  end

  assign st34 = {{2{prof.start[31]}}, prof.start};
  assign s34  = {2'd0, s5};
  assign sum  = prof.neg ? st34 - s34 : st34 + s34;

  always_ff @(posedge clk) begin
    if (en1) begin
      ph1 <= ph_in;
      x1  <= x_in;
    end
    if (en2) begin
      ph2 <= ph1;
      x2  <= x1;
      m2  <= {1'b0, m_in};
    end
    if (en3) begin
      ph3  <= ph2;
      m3   <= m2;
      pl3  <= 64'(m2[31:0]) * 64'(x2);
      ph3p <= 64'(m2[63:32]) * 64'(x2);
    end
    if (en4) begin
      ph4  <= ph3;
      val4 <= (ph3 == PH_CRUISE) ? prof.rd + (m3 >> FRAC_BITS) : ramp;
    end
    if (en5) begin
      ph5 <= ph4;
      s5  <= s_raw[31:0];
    end
    if (en6) begin
      out_phase <= ph5;
      if (sum[33:31] == 3'b000 || sum[33:31] == 3'b111) begin
        out_angle <= sum[31:0];
      end else if (sum[33]) begin
        out_angle <= 32'sh8000_0000;
      end else begin
        out_angle <= 32'sh7fff_ffff;
      end
    end
  end

endmodule

[rtl/trapezoid_motion_profile.sv]
// Trapezoidal velocity profile: set-point angle and phase at a given time.
// Config channel (cfg_valid/cfg_ready, cfg_addr, cfg_data) writes start angle,
// goal angle, peak velocity and acceleration (Q16.16). Each write starts a
// recompute of the move timing (ramp time, ramp distance, cruise time) in a
// serial multiply / divide / square-root sequencer, and while it runs
// cfg_ready and s_tready are low. Reset loads the default move
// (0 to 0, velocity and acceleration 1.0) and runs the same recompute.
// Input beats on s_* carry elapsed time; output beats on m_* carry the angle
// in tdata and the phase in tuser. Six register stages; one beat per cycle is
// sustained while m_tready stays high and no recompute holds s_tready low.
// A full stage holds only while the next one holds, so a stalled m_tready
// fills the bubbles first and only then drops s_tready; nothing is dropped.
// The stages carry the 31x32 velocity/accel multiply followed by the
// split 64x32 ramp product and the final clamp and add.
`include "trapezoid_motion_profile_assert.svh"

module trapezoid_motion_profile #(
  parameter int FRAC_BITS = tmp_pkg::TMP_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] elapsed_time
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] angle_out
  output logic [1:0]  m_tuser    // [1:0] phase
);
  import tmp_pkg::*;

  tmp_prof_t  prof;
  logic       busy;
  logic       eval_ready;
  tmp_phase_t phase;
  logic signed [31:0] angle;

  tmp_cfg #(.FRAC_BITS(FRAC_BITS)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .busy      (busy),
    .prof      (prof)
  );

  // inputs are held off while the move timing is recomputed
  assign s_tready = eval_ready && !busy;

  tmp_eval #(.FRAC_BITS(FRAC_BITS)) u_eval (
    .clk       (clk),
    .rst       (rst),
    .prof      (prof),
    .in_valid  (s_tvalid && !busy),
    .in_ready  (eval_ready),
    .in_time   (s_tdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_angle (angle),
    .out_phase (phase)
  );

  assign m_tdata = angle;
  assign m_tuser = phase;

  // a config beat starts a recompute, which blocks input the next cycle
  `TMP_ASSERT_NEXT(a_cfg_blocks_input, cfg_valid && cfg_ready, !s_tready)
  // with timing ready, input is only refused when the pipe is full and stalled
  `TMP_ASSERT_NOW(a_backpressure_only, !busy && !s_tready, m_tvalid && !m_tready)

endmodule
